@@ rtl/core/assert_macros.svh @@
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/cvf_pkg.sv @@
// types, constants and helpers of the 3x3 window filter
package cvf_pkg;

	localparam int unsigned MAX_WIDTH_DEF  = 1024;
	localparam int unsigned MAX_HEIGHT_DEF = 1024;

	localparam int unsigned CFG_DATA_W  = 24;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned SIZE_REG_W  = 11;

	localparam logic [SIZE_REG_W-1:0] RST_WIDTH  = 11'd640;
	localparam logic [SIZE_REG_W-1:0] RST_HEIGHT = 11'd480;
	localparam logic [23:0] RST_WEIGHTS_TOP    = 24'h000000;
	localparam logic [23:0] RST_WEIGHTS_MIDDLE = 24'h001000;
	localparam logic [23:0] RST_WEIGHTS_BOTTOM = 24'h000000;

	localparam int unsigned MIN_SIZE = 3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_IMAGE_WIDTH    = 3'd0,
		CFG_IMAGE_HEIGHT   = 3'd1,
		CFG_WEIGHTS_TOP    = 3'd2,
		CFG_WEIGHTS_MIDDLE = 3'd3,
		CFG_WEIGHTS_BOTTOM = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic [7:0] pixel_in;
		logic       frame_start;
	} in_word_t;

	typedef struct packed {
		logic [7:0] pixel_out;
		logic       row_end;
		logic       frame_end;
	} out_word_t;

	// per-pixel tags worked out at accept time
	typedef struct packed {
		logic prod;
		logic row_end;
		logic frame_end;
	} pos_flags_t;

	// [row][column][bit], top row and left column at index 0
	typedef logic [2:0][2:0][7:0] kern_t;
	typedef logic [2:0][2:0][7:0] win_t;

	function automatic int unsigned sat_size(logic [SIZE_REG_W-1:0] v, int unsigned hi);
		int unsigned x;
		x = int'(v);
		if (x < MIN_SIZE) return MIN_SIZE;
		if (x > hi) return hi;
		return x;
	endfunction

endpackage

@@ rtl/core/cvf_ram.sv @@
// generic single-write, single-read ram with registered read
module cvf_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/cvf_pos.sv @@
// column and row position counters, valid-window tags
module cvf_pos #(
	parameter int unsigned MAX_WIDTH  = cvf_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = cvf_pkg::MAX_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  logic                            frame_start,
	input  logic [$clog2(MAX_WIDTH):0]      width,
	input  logic [$clog2(MAX_HEIGHT):0]     height,
	output logic [$clog2(MAX_WIDTH)-1:0]    col,
	output cvf_pkg::pos_flags_t             flags
);
	import cvf_pkg::*;

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned RW = $clog2(MAX_HEIGHT);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic [CW:0] c_raw, c0, cn;
	logic [RW:0] r_raw, r_inc, r0, rn, r_next;
	logic        wrap_c, last_col;

	always_comb begin
		c_raw  = frame_start ? '0 : {1'b0, col_q};
		r_raw  = frame_start ? '0 : {1'b0, row_q};
		// a position left beyond a shrunk size wraps first
		wrap_c = (c_raw >= width);
		c0     = wrap_c ? '0 : c_raw;
		r_inc  = wrap_c ? r_raw + (RW+1)'(1) : r_raw;
		r0     = (r_inc >= height) ? '0 : r_inc;
		cn       = c0 + (CW+1)'(1);
		rn       = r0 + (RW+1)'(1);
		last_col = (cn == width);
		r_next   = last_col ? ((rn >= height) ? '0 : rn) : r0;
	end

	always_comb begin
		col             = c0[CW-1:0];
		flags.prod      = (r0 >= (RW+1)'(2)) && (c0 >= (CW+1)'(2));
		flags.row_end   = last_col;
		flags.frame_end = last_col && (rn == height);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= last_col ? '0 : cn[CW-1:0];
			row_q <= r_next[RW-1:0];
		end
	end

endmodule

@@ rtl/core/cvf_window.sv @@
// line store access with write-back bypass, and the 3x3 window register
module cvf_window #(
	parameter int unsigned MAX_WIDTH = cvf_pkg::MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         accept,
	input  logic [7:0]                   pix,
	input  logic [$clog2(MAX_WIDTH)-1:0] col,
	input  cvf_pkg::pos_flags_t          flags,
	output cvf_pkg::win_t                win,
	output logic                         valid_s2,
	output cvf_pkg::pos_flags_t          flags_s2
);
	import cvf_pkg::*;

	localparam int unsigned CW = $clog2(MAX_WIDTH);

	// line word: older row in the high byte, newer row in the low byte
	logic [15:0]   rd_data;
	logic [15:0]   line_eff;
	logic [15:0]   wr_data;
	logic          wr_en;

	logic          valid_s1;
	logic [7:0]    pix_s1;
	logic [CW-1:0] addr_s1;
	logic          fwd_s1;
	logic [15:0]   fwd_data_s1;
	pos_flags_t    flags_s1;

	win_t          win_q;

	assign line_eff = fwd_s1 ? fwd_data_s1 : rd_data;
	assign wr_data  = {line_eff[7:0], pix_s1};
	assign wr_en    = valid_s1 && adv;

	cvf_ram #(
		.WIDTH (16),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (wr_data),
		.re    (accept),
		.raddr (col),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
			// the ram read misses a write to the same column in this cycle
			fwd_s1   <= accept && valid_s1 && (addr_s1 == col);
			valid_s2 <= valid_s1 && flags_s1.prod;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= pix;
			addr_s1     <= col;
			flags_s1    <= flags;
			fwd_data_s1 <= wr_data;
		end
		if (wr_en) begin
			flags_s2 <= flags_s1;
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= line_eff[15:8];
			win_q[1][2] <= line_eff[7:0];
			win_q[2][2] <= pix_s1;
		end
	end

	assign win = win_q;

endmodule

@@ rtl/core/cvf_mac.sv @@
// weighted sum of the window, clamp, and result register
module cvf_mac (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                valid_s2,
	input  cvf_pkg::pos_flags_t flags_s2,
	input  cvf_pkg::win_t       win,
	input  cvf_pkg::kern_t      kern,
	output logic                res_valid,
	output cvf_pkg::out_word_t  res_word
);
	import cvf_pkg::*;

	logic signed [16:0] prod_s3 [3][3];
	logic               valid_s3;
	pos_flags_t         flags_s3;

	logic signed [18:0] rsum_s4 [3];
	logic               valid_s4;
	pos_flags_t         flags_s4;

	logic signed [19:0] total;
	logic [7:0]         clamped;

	always_comb begin
		total = 20'(rsum_s4[0]) + 20'(rsum_s4[1]) + 20'(rsum_s4[2]);
		// sum is in sixteenths: drop the fraction, clip to a byte
		if (total <= 20'sd0) begin
			clamped = 8'd0;
		end else if (total[19:4] > 16'd255) begin
			clamped = 8'd255;
		end else begin
			clamped = total[11:4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			res_valid <= 1'b0;
		end else if (adv) begin
			valid_s3  <= valid_s2;
			valid_s4  <= valid_s3;
			res_valid <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			flags_s3 <= flags_s2;
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s3[i][k] <= 17'($signed(kern[i][k])) *
						17'($signed({1'b0, win[i][k]}));
				end
			end
		end
		if (adv && valid_s3) begin
			flags_s4 <= flags_s3;
			for (int i = 0; i < 3; i++) begin
				rsum_s4[i] <= 19'(prod_s3[i][0]) + 19'(prod_s3[i][1]) +
					19'(prod_s3[i][2]);
			end
		end
		if (adv && valid_s4) begin
			res_word.pixel_out <= clamped;
			res_word.row_end   <= flags_s4.row_end;
			res_word.frame_end <= flags_s4.frame_end;
		end
	end

endmodule

@@ rtl/core/conv3x3_valid_window_filter_unit.sv @@
// top level of the 3x3 valid-window image filter
//
//  channel  direction  handshake               payload
//  pix      in         pix_valid / pix_stall   in_word_t: pixel_in, frame_start
//  res      out        res_valid / res_stall   out_word_t: pixel_out, row_end, frame_end
//  cfg      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one pixel word is taken every clock while pix_stall is low; its data moves through
// s1, s2, s3, s4 and the result register. the line ram is read when a pixel is taken
// and written back from s1; a same-column read meanwhile uses the bypass register.
// all stages move together; pix_stall is high only while a result waits on res_stall.
// reset clears counters and valid bits and loads the default configuration; no clearing pass is run.
`include "assert_macros.svh"

module conv3x3_valid_window_filter_unit #(
	parameter int unsigned MAX_WIDTH  = cvf_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = cvf_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pix_valid,
	output logic                                pix_stall,
	input  cvf_pkg::in_word_t                   pix_word,
	output logic                                res_valid,
	input  logic                                res_stall,
	output cvf_pkg::out_word_t                  res_word,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cvf_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [cvf_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import cvf_pkg::*;

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned RW = $clog2(MAX_HEIGHT);

	localparam logic [CW:0] RST_W = (CW+1)'(sat_size(RST_WIDTH, MAX_WIDTH));
	localparam logic [RW:0] RST_H = (RW+1)'(sat_size(RST_HEIGHT, MAX_HEIGHT));

	logic [CW:0]   width_q;
	logic [RW:0]   height_q;
	kern_t         weights_q;

	logic          adv;
	logic          accept;
	logic [CW-1:0] col;
	pos_flags_t    flags;
	win_t          win;
	logic          valid_s2;
	pos_flags_t    flags_s2;

	assign cfg_ready = 1'b1;
	assign adv       = !res_valid || !res_stall;
	assign pix_stall = !adv;
	assign accept    = pix_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= RST_W;
			height_q     <= RST_H;
			weights_q[0] <= RST_WEIGHTS_TOP;
			weights_q[1] <= RST_WEIGHTS_MIDDLE;
			weights_q[2] <= RST_WEIGHTS_BOTTOM;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_IMAGE_WIDTH: begin
					width_q <= (CW+1)'(sat_size(cfg_data[SIZE_REG_W-1:0], MAX_WIDTH));
				end
				CFG_IMAGE_HEIGHT: begin
					height_q <= (RW+1)'(sat_size(cfg_data[SIZE_REG_W-1:0], MAX_HEIGHT));
				end
				CFG_WEIGHTS_TOP:    weights_q[0] <= cfg_data;
				CFG_WEIGHTS_MIDDLE: weights_q[1] <= cfg_data;
				CFG_WEIGHTS_BOTTOM: weights_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	cvf_pos #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_pos (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.frame_start (pix_word.frame_start),
		.width       (width_q),
		.height      (height_q),
		.col         (col),
		.flags       (flags)
	);

	cvf_window #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.accept   (accept),
		.pix      (pix_word.pixel_in),
		.col      (col),
		.flags    (flags),
		.win      (win),
		.valid_s2 (valid_s2),
		.flags_s2 (flags_s2)
	);

	cvf_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.valid_s2  (valid_s2),
		.flags_s2  (flags_s2),
		.win       (win),
		.kern      (weights_q),
		.res_valid (res_valid),
		.res_word  (res_word)
	);

	`ASSERT_IMPLIES(a_stall_from_output, pix_stall, res_valid && res_stall, "input stalled without a blocked result")
	`ASSERT_IMPLIES(a_frame_end_on_row_end, res_valid && res_word.frame_end, res_word.row_end, "frame end off a row end")
	`ASSERT_ALWAYS(a_width_range, (width_q >= (CW+1)'(3)) && (width_q <= (CW+1)'(MAX_WIDTH)), "width out of range")
	`ASSERT_ALWAYS(a_height_range, (height_q >= (RW+1)'(3)) && (height_q <= (RW+1)'(MAX_HEIGHT)), "height out of range")

endmodule
